FILE: sv/gsbm_pkg.sv
package gsbm_pkg;

    localparam int CELLS   = 64;
    localparam int DATA_W  = 64;
    localparam int WIDTH_W = 7;
    localparam int COORD_W = $clog2(CELLS);
    localparam int CNT_W   = $clog2(CELLS + 1);

    typedef struct packed {
        logic [COORD_W-1:0] col;
        logic [COORD_W-1:0] row;
    } coord_t;

    typedef struct packed {
        logic   found;
        coord_t pos;
    } endpoint_t;

    typedef struct packed {
        endpoint_t a;
        endpoint_t b;
    } hop_t;

    typedef struct packed {
        logic               active;
        logic               x_move;
        logic               x_neg;
        logic               y_move;
        logic               y_neg;
        logic [COORD_W-1:0] xa;
        logic [COORD_W-1:0] ya;
        logic [COORD_W-1:0] n;
    } line_t;

endpackage

FILE: sv/grid_squares_between_mask_unit.sv
// Input is taken in ST_IDLE and passes ST_SCAN (the 64-cell endpoint search chain),
// ST_ALIGN and ST_MARK; no new input is taken until the mask is in the output register.
// A finished result waits in the output register while the next input is processed.
// Reset (aresetn low, synchronous) sets board_width to 8 and empties the output.
// After reset and after every board_width write, s_tready stays low
// while the cell coordinates settle.
module grid_squares_between_mask_unit (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wr_en,
    input  logic [gsbm_pkg::WIDTH_W-1:0]     cfg_wr_data,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [2*gsbm_pkg::DATA_W-1:0]    s_tdata,  // square_a, square_b
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [gsbm_pkg::DATA_W-1:0]      m_tdata   // between_mask
);
    import gsbm_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_SCAN  = 4'b0010,
        ST_ALIGN = 4'b0100,
        ST_MARK  = 4'b1000
    } state_t;

    state_t             state_reg, state_next;
    logic [WIDTH_W-1:0] width_reg, width_next;
    logic [CNT_W-1:0]   settle_reg, settle_next;
    logic [CNT_W-1:0]   scan_reg, scan_next;
    line_t              line_reg, line_next;
    logic               out_valid_reg, out_valid_next;
    logic [DATA_W-1:0]  out_data_reg, out_data_next;

    logic [WIDTH_W-1:0] w_eff;
    logic               settled, accept, out_free;
    coord_t             coord_w [CELLS];
    hop_t               hop_w [CELLS];
    logic [CELLS-1:0]   between_w;
    logic [DATA_W-1:0]  mask_w;

    assign w_eff    = (width_reg == '0) ? WIDTH_W'(1) : width_reg;
    assign settled  = (settle_reg == CNT_W'(CELLS));
    assign s_tready = (state_reg == ST_IDLE) && settled;
    assign accept   = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;

    for (genvar i = 0; i < CELLS; i++) begin : g_cell
        coord_t c_in;
        hop_t   h_in;
        if (i == 0) begin : g_head
            assign c_in = '0;
            assign h_in = '0;
        end else begin : g_body
            assign c_in = coord_w[i-1];
            assign h_in = hop_w[i-1];
        end
        gsbm_cell u_cell (
            .aclk      (aclk),
            .w_eff     (w_eff),
            .seed      (i == 0),
            .coord_in  (c_in),
            .coord_out (coord_w[i]),
            .load      (accept),
            .bit_a     (s_tdata[i]),
            .bit_b     (s_tdata[DATA_W+i]),
            .hop_in    (h_in),
            .hop_out   (hop_w[i]),
            .line      (line_reg),
            .between   (between_w[i])
        );
    end

    gsbm_align u_align (
        .ends (hop_w[CELLS-1]),
        .line (line_next)
    );

    always_comb begin
        mask_w = '0;
        mask_w[CELLS-1:0] = between_w;
    end

    always_comb begin
        state_next     = state_reg;
        width_next     = width_reg;
        settle_next    = settle_reg;
        scan_next      = scan_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;

        if (cfg_wr_en) begin
            width_next  = cfg_wr_data;
            settle_next = '0;
        end else if (!settled) begin
            settle_next = settle_reg + CNT_W'(1);
        end

        if (out_valid_reg && m_tready) begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    scan_next  = '0;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                scan_next = scan_reg + CNT_W'(1);
                if (scan_reg == CNT_W'(CELLS - 1)) begin
                    state_next = ST_ALIGN;
                end
            end
            ST_ALIGN: begin
                state_next = ST_MARK;
            end
            ST_MARK: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_data_next  = mask_w;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            width_reg     <= WIDTH_W'(8);
            settle_reg    <= '0;
            scan_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            width_reg     <= width_next;
            settle_reg    <= settle_next;
            scan_reg      <= scan_next;
            out_valid_reg <= out_valid_next;
        end
        out_data_reg <= out_data_next;
        if (state_reg == ST_ALIGN) begin
            line_reg <= line_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

`ifndef SYNTHESIS
    a_cfg_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_wr_en |=> !s_tready)
        else $error("input taken right after a width write");

    a_load_from_mark: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(state_reg == ST_MARK))
        else $error("result loaded outside the mark step");

    a_scan_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN) |-> (scan_reg < CNT_W'(CELLS)))
        else $error("scan count ran past the chain length");

    a_mark_no_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_MARK) |-> !s_tready)
        else $error("input ready while a mask is being formed");
`endif

endmodule

FILE: sv/gsbm_cell.sv
module gsbm_cell (
    input  logic                         aclk,
    input  logic [gsbm_pkg::WIDTH_W-1:0] w_eff,
    input  logic                         seed,
    input  gsbm_pkg::coord_t             coord_in,
    output gsbm_pkg::coord_t             coord_out,
    input  logic                         load,
    input  logic                         bit_a,
    input  logic                         bit_b,
    input  gsbm_pkg::hop_t               hop_in,
    output gsbm_pkg::hop_t               hop_out,
    input  gsbm_pkg::line_t              line,
    output logic                         between
);
    import gsbm_pkg::*;

    coord_t coord_reg, coord_next;
    logic   bit_a_reg, bit_b_reg;
    hop_t   hop_reg, hop_next;

    logic [WIDTH_W-1:0]      col_p1;
    logic signed [COORD_W:0] dxc, dyc, kx, ky, k, n_s;
    logic                    x_ok, y_ok;

    // advance the coordinate of the previous cell by one position
    always_comb begin
        col_p1 = WIDTH_W'(coord_in.col) + WIDTH_W'(1);
        if (seed) begin
            coord_next = '0;
        end else if (col_p1 >= w_eff) begin
            coord_next.col = '0;
            coord_next.row = coord_in.row + COORD_W'(1);
        end else begin
            coord_next.col = col_p1[COORD_W-1:0];
            coord_next.row = coord_in.row;
        end
    end

    // pass the lowest endpoint seen so far, or claim it here
    always_comb begin
        if (hop_in.a.found) begin
            hop_next.a = hop_in.a;
        end else begin
            hop_next.a.found = bit_a_reg;
            hop_next.a.pos   = coord_reg;
        end
        if (hop_in.b.found) begin
            hop_next.b = hop_in.b;
        end else begin
            hop_next.b.found = bit_b_reg;
            hop_next.b.pos   = coord_reg;
        end
    end

    always_ff @(posedge aclk) begin
        coord_reg <= coord_next;
        hop_reg   <= hop_next;
        if (load) begin
            bit_a_reg <= bit_a;
            bit_b_reg <= bit_b;
        end
    end

    always_comb begin
        dxc = $signed({1'b0, coord_reg.col}) - $signed({1'b0, line.xa});
        dyc = $signed({1'b0, coord_reg.row}) - $signed({1'b0, line.ya});
        kx  = line.x_neg ? -dxc : dxc;
        ky  = line.y_neg ? -dyc : dyc;
        k   = line.x_move ? kx : ky;
        n_s = $signed({1'b0, line.n});
        x_ok = line.x_move ? (kx == k) : (dxc == '0);
        y_ok = line.y_move ? (ky == k) : (dyc == '0);
        between = line.active && x_ok && y_ok && (k > 0) && (k < n_s);
    end

    assign coord_out = coord_reg;
    assign hop_out   = hop_reg;

endmodule

FILE: sv/gsbm_align.sv
module gsbm_align (
    input  gsbm_pkg::hop_t  ends,
    output gsbm_pkg::line_t line
);
    import gsbm_pkg::*;

    logic signed [COORD_W:0] dx, dy;
    logic [COORD_W:0]        adx_w, ady_w;
    logic [COORD_W-1:0]      adx, ady;
    logic                    aligned;

    always_comb begin
        dx    = $signed({1'b0, ends.b.pos.col}) - $signed({1'b0, ends.a.pos.col});
        dy    = $signed({1'b0, ends.b.pos.row}) - $signed({1'b0, ends.a.pos.row});
        adx_w = dx[COORD_W] ? -dx : dx;
        ady_w = dy[COORD_W] ? -dy : dy;
        adx   = adx_w[COORD_W-1:0];
        ady   = ady_w[COORD_W-1:0];
        aligned = (adx == '0) || (ady == '0) || (adx == ady);

        line.active = ends.a.found && ends.b.found && aligned;
        line.x_move = (dx != '0);
        line.x_neg  = dx[COORD_W];
        line.y_move = (dy != '0);
        line.y_neg  = dy[COORD_W];
        line.xa     = ends.a.pos.col;
        line.ya     = ends.a.pos.row;
        line.n      = (adx > ady) ? adx : ady;
    end

endmodule

FILE: dv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

    import gsbm_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int HOLD_CYCLES    = 400;
    localparam int PHASE_ITEMS    = 100;
    localparam int MAX_REPORTS    = 10;

    typedef struct {
        logic [DATA_W-1:0] sq_a;
        logic [DATA_W-1:0] sq_b;
    } pair_t;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   cfg_wr_en = 1'b0;
    logic [WIDTH_W-1:0]     cfg_wr_data = '0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [2*DATA_W-1:0]    s_tdata = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [DATA_W-1:0]      m_tdata;

    pair_t                  pair_q[$];
    logic [DATA_W-1:0]      between_q[$];
    logic [WIDTH_W-1:0]     model_width = 7'd8;
    int                     send_idle_pct = 0;
    int                     recv_stall_pct = 0;
    int                     mismatch_cnt = 0;
    int                     stall_cnt = 0;
    int                     hold_cnt = 0;
    logic                   hold_req = 1'b0;
    logic                   hold_done = 1'b0;

    grid_squares_between_mask_unit u_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    function automatic logic [DATA_W-1:0] calc_between(logic [DATA_W-1:0] sa,
                                                       logic [DATA_W-1:0] sb,
                                                       logic [WIDTH_W-1:0] wreg);
        int w, ia, ib, xa, ya, xb, yb, dx, dy, adx, ady, sx, sy, x, y, idx, n;
        logic [DATA_W-1:0] between;
        between = '0;
        if (sa == '0 || sb == '0) return '0;
        w  = (wreg == '0) ? 1 : int'(wreg);
        ia = 0;
        while (ia < CELLS - 1 && !sa[ia]) ia++;
        ib = 0;
        while (ib < CELLS - 1 && !sb[ib]) ib++;
        xa  = ia % w;
        ya  = ia / w;
        xb  = ib % w;
        yb  = ib / w;
        dx  = xb - xa;
        dy  = yb - ya;
        adx = (dx < 0) ? -dx : dx;
        ady = (dy < 0) ? -dy : dy;
        if (!(adx == 0 || ady == 0 || adx == ady)) return '0;
        sx = (dx > 0) ? 1 : ((dx < 0) ? -1 : 0);
        sy = (dy > 0) ? 1 : ((dy < 0) ? -1 : 0);
        x  = xa + sx;
        y  = ya + sy;
        for (n = 0; n < CELLS && (x != xb || y != yb); n++) begin
            idx = y * w + x;
            if (idx >= 0 && idx < CELLS) between[idx] = 1'b1;
            x += sx;
            y += sy;
        end
        return between;
    endfunction

    // lowest set bit at idx, optionally with random bits above it
    function automatic logic [DATA_W-1:0] square_bits(int idx, bit noisy);
        logic [DATA_W-1:0] bits;
        bits = {{(DATA_W-1){1'b0}}, 1'b1} << idx;
        if (noisy)
            bits |= {$urandom, $urandom} & ~((64'd2 << idx) - 64'd1);
        return bits;
    endfunction

    task automatic push_pair(logic [DATA_W-1:0] sa, logic [DATA_W-1:0] sb);
        pair_t p;
        p.sq_a = sa;
        p.sq_b = sb;
        pair_q.push_back(p);
    endtask

    task automatic queue_random(int count);
        int kind, ia, ib, w, j, adx, ady;
        int cand[$];
        logic [DATA_W-1:0] sa, sb;
        w = (model_width == '0) ? 1 : int'(model_width);
        repeat (count) begin
            kind = $urandom_range(99);
            ia   = $urandom_range(CELLS - 1);
            ib   = $urandom_range(CELLS - 1);
            if (kind < 72) begin
                cand.delete();
                for (j = 0; j < CELLS; j++) begin
                    adx = (j % w > ia % w) ? j % w - ia % w : ia % w - j % w;
                    ady = (j / w > ia / w) ? j / w - ia / w : ia / w - j / w;
                    if (j != ia && (adx == 0 || ady == 0 || adx == ady))
                        cand.push_back(j);
                end
                if (cand.size() != 0)
                    ib = cand[$urandom_range(cand.size() - 1)];
            end else if (kind < 78) begin
                ib = ia;
            end
            sa = square_bits(ia, $urandom_range(3) == 0);
            sb = square_bits(ib, $urandom_range(3) == 0);
            if (kind >= 90) begin
                sa = {$urandom, $urandom};
                sb = {$urandom, $urandom};
                if (kind >= 97) begin
                    if ($urandom_range(1)) sa = '0;
                    else sb = '0;
                end
            end
            push_pair(sa, sb);
        end
    endtask

    task automatic wait_drain();
        while (pair_q.size() != 0 || s_tvalid || between_q.size() != 0)
            @(negedge aclk);
    endtask

    task automatic write_width(logic [WIDTH_W-1:0] wv);
        @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= wv;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        model_width = wv;
        @(negedge aclk);
    endtask

    // input driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready)
                between_q.push_back(calc_between(s_tdata[DATA_W-1:0],
                                                 s_tdata[2*DATA_W-1:DATA_W], model_width));
            if (!s_tvalid || s_tready) begin
                if (pair_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= {pair_q[0].sq_b, pair_q[0].sq_a};
                    void'(pair_q.pop_front());
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // long receiver hold-off
    always @(posedge aclk) begin
        if (!aresetn) begin
            hold_cnt  <= 0;
            hold_done <= 1'b0;
        end else if (hold_req && !hold_done) begin
            hold_cnt  <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else if (hold_cnt != 0) begin
            hold_cnt <= hold_cnt - 1;
        end
    end

    // result monitor
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= (hold_cnt == 0) && ($urandom_range(99) >= recv_stall_pct);
            if (m_tvalid && m_tready) begin
                if (between_q.size() == 0) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= MAX_REPORTS)
                        $display("unexpected transaction: between_mask=%h", m_tdata);
                end else begin
                    if (m_tdata !== between_q[0]) begin
                        mismatch_cnt++;
                        if (mismatch_cnt <= MAX_REPORTS)
                            $display("between_mask mismatch: expected %h actual %h",
                                     between_q[0], m_tdata);
                    end
                    void'(between_q.pop_front());
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                stall_cnt <= 0;
            else
                stall_cnt <= stall_cnt + 1;
            if (stall_cnt >= WATCHDOG_LIMIT) begin
                $display("grid_squares_between_mask_unit verification failed");
                $finish;
            end
        end
    end

    initial begin
        logic [WIDTH_W-1:0] widths[8];
        int                 phase;
        widths = '{7'd1, 7'd64, 7'd0, 7'd127, 7'd8, 7'd3, 7'd5, 7'd11};

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // endpoints at width 8
        push_pair(64'd0, 64'd0);
        push_pair(64'd0, 64'd1 << 5);
        push_pair(64'd1 << 5, 64'd0);
        push_pair(64'd1, 64'd1 << 63);
        push_pair(64'd1 << 63, 64'd1);
        push_pair(64'd1, 64'd1 << 7);
        push_pair(64'd1 << 56, 64'd1);
        push_pair(64'd1 << 7, 64'd1 << 56);
        push_pair(64'd1 << 27, 64'd1 << 27);
        push_pair(64'd1 << 27, 64'd1 << 28);
        push_pair(64'd1 << 27, 64'd1 << 36);
        push_pair(64'd1, 64'd1 << 17);
        push_pair({64{1'b1}}, 64'hFFFF_0000_0000_0000);
        push_pair({64{1'b1}}, {64{1'b1}});
        push_pair(64'd1 << 7, 64'd1 << 8);
        push_pair(64'h8000_0000_0000_0001, 64'h0000_0000_0000_8000);
        push_pair(64'd1 << 63, 64'd1 << 7);
        push_pair(64'hAAAA_AAAA_AAAA_AAA8, 64'h5555_5555_5555_5540);
        wait_drain();

        for (phase = 0; phase < 8; phase++) begin
            write_width(widths[phase]);
            case (phase % 4)
                0: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1: begin
                    send_idle_pct  = 50;
                    recv_stall_pct = 0;
                end
                2: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 50;
                end
                default: begin
                    send_idle_pct  = 33;
                    recv_stall_pct = 33;
                end
            endcase
            queue_random(PHASE_ITEMS);
            if (phase == 4)
                hold_req = 1'b1;
            wait_drain();
        end

        repeat (100) @(posedge aclk);
        if (mismatch_cnt == 0)
            $display("grid_squares_between_mask_unit verification clean");
        else
            $display("grid_squares_between_mask_unit verification failed");
        $finish;
    end

endmodule
